FILE: rtl/core/flbp_pkg.sv
// Shared types, widths and reset constants of the fault LED blink pattern block.
// No dependencies; used by every module under rtl/core.
package flbp_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned ColorW   = 24;
  localparam int unsigned DurW     = 16;
  localparam int unsigned CountW   = 8;
  localparam int unsigned SumW     = DurW + 1;
  localparam int unsigned ProdW    = SumW + CountW;
  localparam int unsigned ModW     = ProdW + 1;
  localparam int unsigned MulCntW  = $clog2(CountW);
  localparam int unsigned DivCntW  = $clog2(TimeW);
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = ColorW;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 64;

  localparam logic [ColorW-1:0] OkColorRst    = 24'h00FF00;
  localparam logic [ColorW-1:0] FaultColorRst = 24'hFF0000;
  localparam logic [DurW-1:0]   OnTimeRst     = 16'd150;
  localparam logic [DurW-1:0]   OffTimeRst    = 16'd150;
  localparam logic [DurW-1:0]   GapTimeRst    = 16'd900;
  localparam logic [CountW-1:0] PulseCountRst = 8'd2;

  localparam logic [1:0] ValidFaultId = 2'd1;

  typedef enum logic [2:0] {
    CFG_OK_COLOR,
    CFG_FAULT_COLOR,
    CFG_ON_TIME,
    CFG_OFF_TIME,
    CFG_GAP_TIME,
    CFG_PULSE_COUNT
  } flbp_cfg_e;

  typedef enum logic [1:0] {
    PH_SOLID,
    PH_PULSE_ON,
    PH_PULSE_OFF,
    PH_GAP
  } flbp_phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SETUP,
    ST_MOD1,
    ST_MOD2,
    ST_DONE
  } flbp_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } flbp_unit_stat_t;

endpackage

FILE: rtl/core/flbp_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// Depends on flbp_pkg.
module flbp_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [flbp_pkg::SumW-1:0]     mcand_i,
  input  logic [flbp_pkg::CountW-1:0]   mplier_i,
  output logic [flbp_pkg::ProdW-1:0]    prod_o,
  output flbp_pkg::flbp_unit_stat_t     stat_o
);

  logic [flbp_pkg::ProdW-1:0]   acc_q;
  logic [flbp_pkg::ProdW-1:0]   mc_q;
  logic [flbp_pkg::CountW-1:0]  mp_q;
  logic [flbp_pkg::MulCntW-1:0] cnt_q;
  logic                         busy_q;
  logic                         done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == flbp_pkg::MulCntW'(flbp_pkg::CountW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      mc_q  <= {{flbp_pkg::CountW{1'b0}}, mcand_i};
      mp_q  <= mplier_i;
    end else if (busy_q) begin
      if (mp_q[0]) begin
        acc_q <= acc_q + mc_q;
      end
      mc_q <= mc_q << 1;
      mp_q <= mp_q >> 1;
    end
  end

  assign prod_o      = acc_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

FILE: rtl/core/flbp_div.sv
// Radix-2 restoring remainder unit: one dividend bit per cycle.
// Depends on flbp_pkg.
module flbp_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [flbp_pkg::TimeW-1:0]  dividend_i,
  input  logic [flbp_pkg::ModW-1:0]   divisor_i,
  output logic [flbp_pkg::ModW-1:0]   rem_o,
  output flbp_pkg::flbp_unit_stat_t   stat_o
);

  logic [flbp_pkg::TimeW-1:0]   dvd_q;
  logic [flbp_pkg::ModW-1:0]    dsr_q;
  logic [flbp_pkg::ModW-1:0]    rem_q;
  logic [flbp_pkg::DivCntW-1:0] cnt_q;
  logic                         busy_q;
  logic                         done_q;
  logic [flbp_pkg::ModW:0]      trial;
  logic                         fits;

  assign trial = {rem_q, dvd_q[flbp_pkg::TimeW-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == flbp_pkg::DivCntW'(flbp_pkg::TimeW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      if (fits) begin
        rem_q <= flbp_pkg::ModW'(trial - {1'b0, dsr_q});
      end else begin
        rem_q <= trial[flbp_pkg::ModW-1:0];
      end
    end
  end

  assign rem_o       = rem_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

FILE: rtl/core/fault_led_blink_pattern.sv
// Fault LED blink pattern: one request at a time, result held in an output register.
// Set requests and ticks with no fault raised go straight to the result; a fault tick runs
// a serial multiply, then one remainder pass in the gap or two in a burst. A new request
// is taken only once the previous result has been loaded into the output register.
// Reset: config registers to defaults, fault and send state cleared; no clearing pass.
// Depends on flbp_pkg, flbp_mul and flbp_div.
module fault_led_blink_pattern (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // fault_id[1:0], fault_active[2], now_ms[34:3], link_ok[35], zero[39:36]
  input  logic [flbp_pkg::InDataW-1:0]   s_axis_tdata_i,
  // action[0]
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // set_accepted[0], send_valid[1], red[9:2], green[17:10], blue[25:18],
  // phase[27:26], failure_count[59:28], zero[63:60]
  output logic [flbp_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input  logic                           cfg_we_i,
  input  logic [flbp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [flbp_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned TimeW  = flbp_pkg::TimeW;
  localparam int unsigned ColorW = flbp_pkg::ColorW;
  localparam int unsigned DurW   = flbp_pkg::DurW;
  localparam int unsigned CountW = flbp_pkg::CountW;
  localparam int unsigned SumW   = flbp_pkg::SumW;
  localparam int unsigned ProdW  = flbp_pkg::ProdW;
  localparam int unsigned ModW   = flbp_pkg::ModW;

  flbp_pkg::flbp_state_e state_q, state_d;

  logic [ColorW-1:0] ok_color_q, fault_color_q;
  logic [DurW-1:0]   on_time_q, off_time_q, gap_time_q;
  logic [CountW-1:0] pulse_count_q;

  logic              fault_raised_q, fault_shown_q, sent_valid_q;
  logic [TimeW-1:0]  pat_start_q, fail_q;
  logic [ColorW-1:0] last_color_q;

  logic              is_tick_q, link_q, set_acc_q;
  logic [TimeW-1:0]  elapsed_q;
  logic [ProdW-1:0]  limit_q;
  logic [ModW-1:0]   cycle_q, cycle_d;
  logic [ColorW-1:0] color_q;
  flbp_pkg::flbp_phase_e phase_q;

  logic              out_valid_q;
  logic [flbp_pkg::OutDataW-1:0] out_q;

  logic              in_action, in_fault_act, in_link;
  logic [1:0]        in_fid;
  logic [TimeW-1:0]  in_now;
  logic              in_acc, changed, load_out, send, pos_in_burst, lit;
  logic [SumW-1:0]   period;
  logic [CountW-1:0] n_pulses;
  logic [ModW-1:0]   pos;

  logic              mul_start, div_start;
  logic [TimeW-1:0]  div_dvd;
  logic [ModW-1:0]   div_dsr, div_rem;
  logic [ProdW-1:0]  mul_prod;
  flbp_pkg::flbp_unit_stat_t mul_stat, div_stat;

  assign in_fid       = s_axis_tdata_i[1:0];
  assign in_fault_act = s_axis_tdata_i[2];
  assign in_now       = s_axis_tdata_i[34:3];
  assign in_link      = s_axis_tdata_i[35];
  assign in_action    = s_axis_tuser_i;

  assign s_axis_tready_o = (state_q == flbp_pkg::ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign changed         = fault_raised_q != fault_shown_q;

  assign period   = {1'b0, on_time_q} + {1'b0, off_time_q};
  assign n_pulses = (pulse_count_q == '0) ? CountW'(1) : pulse_count_q;
  assign cycle_d  = {1'b0, limit_q} + ModW'(gap_time_q);
  assign pos      = (cycle_q == '0) ? '0 : div_rem;
  assign pos_in_burst = pos < {1'b0, limit_q};
  assign lit      = div_rem < ModW'(on_time_q);

  assign load_out = (state_q == flbp_pkg::ST_DONE) && (!out_valid_q || m_axis_tready_i);
  assign send     = is_tick_q && !(sent_valid_q && (color_q == last_color_q));

  flbp_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (period),
    .mplier_i (n_pulses),
    .prod_o   (mul_prod),
    .stat_o   (mul_stat)
  );

  flbp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .rem_o      (div_rem),
    .stat_o     (div_stat)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      flbp_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_action && fault_raised_q) begin
            state_d = flbp_pkg::ST_MUL;
          end else begin
            state_d = flbp_pkg::ST_DONE;
          end
        end
      end
      flbp_pkg::ST_MUL: begin
        if (mul_stat.done) state_d = flbp_pkg::ST_SETUP;
      end
      flbp_pkg::ST_SETUP: begin
        state_d = flbp_pkg::ST_MOD1;
      end
      flbp_pkg::ST_MOD1: begin
        if (div_stat.done) begin
          state_d = pos_in_burst ? flbp_pkg::ST_MOD2 : flbp_pkg::ST_DONE;
        end
      end
      flbp_pkg::ST_MOD2: begin
        if (div_stat.done) state_d = flbp_pkg::ST_DONE;
      end
      flbp_pkg::ST_DONE: begin
        if (load_out) state_d = flbp_pkg::ST_IDLE;
      end
      default: state_d = flbp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    div_dvd   = elapsed_q;
    div_dsr   = cycle_d;
    case (state_q)
      flbp_pkg::ST_IDLE: begin
        mul_start = in_acc && in_action && fault_raised_q;
      end
      flbp_pkg::ST_SETUP: begin
        div_start = 1'b1;
      end
      flbp_pkg::ST_MOD1: begin
        div_start = div_stat.done && pos_in_burst;
        div_dvd   = TimeW'(pos);
        div_dsr   = ModW'(period);
      end
      default: begin
        mul_start = 1'b0;
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= flbp_pkg::ST_IDLE;
      ok_color_q     <= flbp_pkg::OkColorRst;
      fault_color_q  <= flbp_pkg::FaultColorRst;
      on_time_q      <= flbp_pkg::OnTimeRst;
      off_time_q     <= flbp_pkg::OffTimeRst;
      gap_time_q     <= flbp_pkg::GapTimeRst;
      pulse_count_q  <= flbp_pkg::PulseCountRst;
      fault_raised_q <= 1'b0;
      fault_shown_q  <= 1'b0;
      pat_start_q    <= '0;
      last_color_q   <= '0;
      sent_valid_q   <= 1'b0;
      fail_q         <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (flbp_pkg::flbp_cfg_e'(cfg_idx_i))
          flbp_pkg::CFG_OK_COLOR:    ok_color_q    <= cfg_data_i;
          flbp_pkg::CFG_FAULT_COLOR: fault_color_q <= cfg_data_i;
          flbp_pkg::CFG_ON_TIME:     on_time_q     <= cfg_data_i[DurW-1:0];
          flbp_pkg::CFG_OFF_TIME:    off_time_q    <= cfg_data_i[DurW-1:0];
          flbp_pkg::CFG_GAP_TIME:    gap_time_q    <= cfg_data_i[DurW-1:0];
          flbp_pkg::CFG_PULSE_COUNT: pulse_count_q <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        if (!in_action) begin
          if (in_fid == flbp_pkg::ValidFaultId) fault_raised_q <= in_fault_act;
        end else if (changed) begin
          fault_shown_q <= fault_raised_q;
          pat_start_q   <= in_now;
        end
      end
      if (load_out) begin
        if (send) begin
          if (link_q) begin
            last_color_q <= color_q;
            sent_valid_q <= 1'b1;
          end else begin
            sent_valid_q <= 1'b0;
            fail_q       <= fail_q + 1'b1;
          end
        end
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      is_tick_q <= in_action;
      link_q    <= in_link;
      set_acc_q <= !in_action && (in_fid == flbp_pkg::ValidFaultId);
      elapsed_q <= changed ? '0 : in_now - pat_start_q;
      color_q   <= (in_action && !fault_raised_q) ? ok_color_q : '0;
      phase_q   <= flbp_pkg::PH_SOLID;
    end
    if (state_q == flbp_pkg::ST_MUL && mul_stat.done) begin
      limit_q <= mul_prod - ProdW'(off_time_q);
    end
    if (state_q == flbp_pkg::ST_SETUP) begin
      cycle_q <= cycle_d;
    end
    if (state_q == flbp_pkg::ST_MOD1 && div_stat.done && !pos_in_burst) begin
      color_q <= '0;
      phase_q <= flbp_pkg::PH_GAP;
    end
    if (state_q == flbp_pkg::ST_MOD2 && div_stat.done) begin
      color_q <= lit ? fault_color_q : '0;
      phase_q <= lit ? flbp_pkg::PH_PULSE_ON : flbp_pkg::PH_PULSE_OFF;
    end
    if (load_out) begin
      out_q <= {4'b0000,
                (send && !link_q) ? fail_q + 1'b1 : fail_q,
                phase_q,
                color_q[7:0],
                color_q[15:8],
                color_q[23:16],
                send,
                set_acc_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

`ifndef SYNTH
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_stat.busy && div_stat.busy))
    else $error("multiplier and remainder unit busy together");

  a_ready_units_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !mul_stat.busy && !div_stat.busy)
    else $error("request accepted while a unit is still busy");

  a_fail_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fail_q != $past(fail_q) |-> fail_q == $past(fail_q) + 32'd1)
    else $error("failure counter moved by more than one");

  a_load_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> state_q == flbp_pkg::ST_IDLE && m_axis_tvalid_o)
    else $error("result load did not return to idle");
`endif

endmodule
